// ===== rtl/cia_pkg.sv =====
// Shared types, operation and status codes for the checked 32-bit ALU.
package cia_pkg;

   localparam int Width = 32;
   localparam int DivStepsDefault = 4;

   localparam logic [3:0] CMD_NEG = 4'd0;
   localparam logic [3:0] CMD_ADD = 4'd1;
   localparam logic [3:0] CMD_SUB = 4'd2;
   localparam logic [3:0] CMD_MUL = 4'd3;
   localparam logic [3:0] CMD_DIV = 4'd4;
   localparam logic [3:0] CMD_MOD = 4'd5;
   localparam logic [3:0] CMD_OR  = 4'd6;
   localparam logic [3:0] CMD_XOR = 4'd7;
   localparam logic [3:0] CMD_AND = 4'd8;
   localparam logic [3:0] CMD_SHL = 4'd9;
   localparam logic [3:0] CMD_SAR = 4'd10;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_OVF   = 2'd1;
   localparam logic [1:0] ST_DIV0  = 2'd2;
   localparam logic [1:0] ST_SHIFT = 2'd3;

   typedef struct packed {
      logic [3:0]         command;
      logic signed [31:0] left;
      logic signed [31:0] right;
   } cia_req_type;

   typedef struct packed {
      logic signed [31:0] value_out;
      logic [1:0]         status;
   } cia_rsp_type;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [63:0] prod;
      logic [31:0] fast_val;
      logic [1:0]  fast_st;
      logic        a_neg;
      logic        b_neg;
      logic [31:0] dvs;
      logic [31:0] rem;
      logic [31:0] quo;
   } cia_work_type;

endpackage

// ===== rtl/cia_front.sv =====
// Operand decode, simple operations, multiplier and divider setup.
module cia_front
   import cia_pkg::*;
(
   input  cia_req_type  req_item,
   output cia_work_type work
);

   logic [32:0] sum33;
   logic [32:0] dif33;
   logic [32:0] neg33;
   logic        big_shift;

   always_comb begin
      sum33 = {req_item.left[31], req_item.left} + {req_item.right[31], req_item.right};
      dif33 = {req_item.left[31], req_item.left} - {req_item.right[31], req_item.right};
      neg33 = 33'd0 - {req_item.left[31], req_item.left};
      big_shift = |req_item.right[30:5];

      work.cmd = req_item.command;
      work.prod = 64'(req_item.left * req_item.right);
      work.a_neg = req_item.left[31];
      work.b_neg = req_item.right[31];
      work.dvs = req_item.right[31] ? 32'(-req_item.right) : req_item.right;
      work.quo = req_item.left[31] ? 32'(-req_item.left) : req_item.left;
      work.rem = '0;
      work.fast_val = '0;
      work.fast_st = ST_OK;

      unique case (req_item.command)
         CMD_NEG: begin
            work.fast_val = neg33[31:0];
            if (neg33[32] != neg33[31]) work.fast_st = ST_OVF;
         end
         CMD_ADD: begin
            work.fast_val = sum33[31:0];
            if (sum33[32] != sum33[31]) work.fast_st = ST_OVF;
         end
         CMD_SUB: begin
            work.fast_val = dif33[31:0];
            if (dif33[32] != dif33[31]) work.fast_st = ST_OVF;
         end
         CMD_DIV, CMD_MOD: begin
            if (req_item.right == 32'sd0) work.fast_st = ST_DIV0;
         end
         CMD_OR:  work.fast_val = req_item.left | req_item.right;
         CMD_XOR: work.fast_val = req_item.left ^ req_item.right;
         CMD_AND: work.fast_val = req_item.left & req_item.right;
         CMD_SHL: begin
            if (req_item.right[31]) work.fast_st = ST_SHIFT;
            else if (big_shift) work.fast_val = '0;
            else work.fast_val = req_item.left << req_item.right[4:0];
         end
         CMD_SAR: begin
            if (req_item.right[31]) work.fast_st = ST_SHIFT;
            else if (big_shift) work.fast_val = {32{req_item.left[31]}};
            else work.fast_val = req_item.left >>> req_item.right[4:0];
         end
         default: work.fast_val = '0;
      endcase
   end

endmodule

// ===== rtl/cia_div_stage.sv =====
// A few restoring division steps for one pipeline stage.
module cia_div_stage
   import cia_pkg::*;
#(
   parameter int STEPS = DivStepsDefault
) (
   input  cia_work_type work_in,
   output cia_work_type work_out
);

   logic [31:0] rem;
   logic [31:0] quo;
   logic [32:0] part;
   logic        ge;

   always_comb begin
      rem = work_in.rem;
      quo = work_in.quo;
      part = '0;
      ge = 1'b0;
      for (int k = 0; k < STEPS; k++) begin
         part = {rem, quo[31]};
         ge = part >= {1'b0, work_in.dvs};
         if (ge) part = part - {1'b0, work_in.dvs};
         rem = part[31:0];
         quo = {quo[30:0], ge};
      end
      work_out = work_in;
      work_out.rem = rem;
      work_out.quo = quo;
   end

endmodule

// ===== rtl/cia_back.sv =====
// Final result: product range check, floor quotient and modulo, error zeroing.
module cia_back
   import cia_pkg::*;
(
   input  cia_work_type work,
   output cia_rsp_type  rsp_item
);

   logic [31:0] val;
   logic [1:0]  st;
   logic [32:0] q33;
   logic        rnz;

   always_comb begin
      val = work.fast_val;
      st = work.fast_st;
      rnz = |work.rem;
      q33 = {1'b0, work.quo};
      if (work.a_neg != work.b_neg) begin
         q33 = rnz ? ~{1'b0, work.quo} : 33'(-{1'b0, work.quo});
      end

      unique case (work.cmd)
         CMD_MUL: begin
            val = work.prod[31:0];
            if (!((&work.prod[63:31]) || !(|work.prod[63:31]))) st = ST_OVF;
         end
         CMD_DIV: begin
            val = q33[31:0];
            if (st == ST_OK && q33[32] != q33[31]) st = ST_OVF;
         end
         CMD_MOD: begin
            if (work.a_neg == work.b_neg || !rnz) begin
               val = work.a_neg ? 32'(-work.rem) : work.rem;
            end else begin
               val = work.b_neg ? work.rem - work.dvs : work.dvs - work.rem;
            end
         end
         default: val = work.fast_val;
      endcase

      rsp_item.status = st;
      rsp_item.value_out = (st != ST_OK) ? '0 : val;
   end

endmodule

// ===== rtl/checked_int32_alu.sv =====
// Top level: pipelined checked 32-bit ALU with floor division.
//
//   channel  direction  handshake                payload
//   req      in         req_valid / req_stall    req_item (command, left, right)
//   rsp      out        rsp_valid / rsp_stall    rsp_item (value_out, status)
//
// The pipeline has one front stage with the multiplier, one stage per
// DIV_STEPS restoring division steps and one result stage. One item enters
// per cycle while req_stall is low.
// Reset clears all stage valid bits; no data is cleared.
// Each stage moves on when the next is empty or moving, so bubbles close up
// under a stall and req_stall rises only when every stage is full.
module checked_int32_alu
   import cia_pkg::*;
#(
   parameter int DIV_STEPS = DivStepsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  cia_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output cia_rsp_type rsp_item
);

   localparam int DivStages = Width / DIV_STEPS;
   localparam int Stages = DivStages + 2;

   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] ready;
   cia_work_type      stage_ff [Stages-1];
   cia_work_type      stage_in [Stages-1];
   cia_rsp_type       rsp_ff;
   cia_rsp_type       rsp_in;

   cia_front u_front (.req_item(req_item), .work(stage_in[0]));

   for (genvar i = 1; i < Stages - 1; i++) begin : g_div
      cia_div_stage #(.STEPS(DIV_STEPS)) u_div (
         .work_in (stage_ff[i-1]),
         .work_out(stage_in[i])
      );
   end

   cia_back u_back (.work(stage_ff[Stages-2]), .rsp_item(rsp_in));

   always_comb begin
      ready[Stages-1] = !valid_ff[Stages-1] || !rsp_stall;
      for (int i = Stages - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= req_valid;
         for (int i = 1; i < Stages; i++) begin
            if (ready[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Stages - 1; i++) begin
         if (ready[i]) stage_ff[i] <= stage_in[i];
      end
      if (ready[Stages-1]) rsp_ff <= rsp_in;
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[Stages-1];
   assign rsp_item = rsp_ff;

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted item not in first stage");
   a_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> &valid_ff)
      else $error("input stalled with an empty stage");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[Stages-1] && rsp_stall && valid_ff[Stages-2] |=> valid_ff[Stages-2])
      else $error("item dropped behind stalled output");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_OK |-> rsp_item.value_out == '0)
      else $error("error result not zeroed");

endmodule

// ===== sim/checked_int32_alu_test.sv =====
// Self-checking testbench for the checked 32-bit ALU: directed table plus random items.
`timescale 1ns / 1ps
module checked_int32_alu_test;
   import cia_pkg::*;

   localparam int NumRandom = 1400;
   localparam logic [31:0] MinVal = 32'h8000_0000;
   localparam logic [31:0] MaxVal = 32'h7fff_ffff;

   typedef struct {
      cia_req_type req;
      logic        known;
      cia_rsp_type rsp;
   } vector_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   cia_req_type req_item;
   logic        rsp_valid;
   logic        rsp_stall;
   cia_rsp_type rsp_item;

   cia_rsp_type pending_q[$];
   int          error_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   vector_type  vectors[$];

   checked_int32_alu uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic cia_rsp_type alu_result(cia_req_type r);
      cia_rsp_type res;
      logic signed [63:0] a, b, v, q, m;
      logic [31:0] ua, ub;
      a = r.left;
      b = r.right;
      ua = r.left;
      ub = r.right;
      v = 0;
      res.status = ST_OK;
      res.value_out = '0;
      case (r.command)
         CMD_NEG: v = -a;
         CMD_ADD: v = a + b;
         CMD_SUB: v = a - b;
         CMD_MUL: v = a * b;
         CMD_DIV, CMD_MOD: begin
            if (b == 0) begin
               res.status = ST_DIV0;
            end else begin
               q = a / b;
               m = a % b;
               if (m != 0 && ((m < 0) != (b < 0))) begin
                  q = q - 1;
                  m = m + b;
               end
               v = (r.command == CMD_DIV) ? q : m;
            end
         end
         CMD_OR:  v = $signed(ua | ub);
         CMD_XOR: v = $signed(ua ^ ub);
         CMD_AND: v = $signed(ua & ub);
         CMD_SHL, CMD_SAR: begin
            if (b < 0) begin
               res.status = ST_SHIFT;
            end else if (r.command == CMD_SHL) begin
               v = (b >= 32) ? 0 : $signed(ua << b[5:0]);
            end else begin
               v = (b >= 32) ? (a < 0 ? -1 : 0) : (a >>> b[5:0]);
            end
         end
         default: v = 0;
      endcase
      if (res.status == ST_OK && (v > 64'sd2147483647 || v < -64'sd2147483648))
         res.status = ST_OVF;
      if (res.status == ST_OK)
         res.value_out = v[31:0];
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   task automatic add_row(logic [3:0] c, logic [31:0] l, logic [31:0] r, logic known,
                          logic [31:0] v, logic [1:0] s);
      vector_type e;
      e.req.command = c;
      e.req.left = l;
      e.req.right = r;
      e.known = known;
      e.rsp.value_out = v;
      e.rsp.status = s;
      vectors.push_back(e);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 5))
         0: return MinVal;
         1: return MaxVal;
         2: return $urandom_range(0, 40);
         3: return -$urandom_range(0, 40);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(cia_req_type r);
      cia_rsp_type want;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (req_stall);
      want = alu_result(r);
      pending_q.push_back(want);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_q.size() == 0) begin
               report_mismatch("result with none expected");
            end else begin
               if (rsp_item.value_out !== pending_q[0].value_out)
                  report_mismatch($sformatf("value_out %h, want %h",
                                  rsp_item.value_out, pending_q[0].value_out));
               if (rsp_item.status !== pending_q[0].status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                  rsp_item.status, pending_q[0].status));
               void'(pending_q.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   initial begin
      #2_000_000;
      $display("checked_int32_alu_test: errors");
      $finish;
   end

   initial begin
      cia_req_type r;
      cia_rsp_type got;
      int phase_len;
      error_count = 0;
      send_idle_pct = 29;
      recv_idle_pct = 60;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      add_row(CMD_NEG, MinVal, 32'd5, 1'b1, 32'd0, ST_OVF);
      add_row(CMD_NEG, MaxVal, MinVal, 1'b1, 32'h8000_0001, ST_OK);
      add_row(CMD_ADD, MaxVal, 32'd1, 1'b1, 32'd0, ST_OVF);
      add_row(CMD_ADD, MinVal, 32'hffff_ffff, 1'b1, 32'd0, ST_OVF);
      add_row(CMD_SUB, MinVal, 32'd1, 1'b1, 32'd0, ST_OVF);
      add_row(CMD_SUB, 32'd7, 32'd9, 1'b1, 32'hffff_fffe, ST_OK);
      add_row(CMD_MUL, MaxVal, 32'd2, 1'b1, 32'd0, ST_OVF);
      add_row(CMD_MUL, MinVal, 32'hffff_ffff, 1'b1, 32'd0, ST_OVF);
      add_row(CMD_MUL, 32'hffff_fffd, 32'd7, 1'b0, 32'd0, ST_OK);
      add_row(CMD_DIV, 32'd5, 32'd0, 1'b1, 32'd0, ST_DIV0);
      add_row(CMD_MOD, 32'd5, 32'd0, 1'b1, 32'd0, ST_DIV0);
      add_row(CMD_DIV, MinVal, 32'hffff_ffff, 1'b1, 32'd0, ST_OVF);
      add_row(CMD_MOD, MinVal, 32'hffff_ffff, 1'b1, 32'd0, ST_OK);
      add_row(CMD_DIV, 32'hffff_fff9, 32'd2, 1'b1, 32'hffff_fffc, ST_OK);
      add_row(CMD_MOD, 32'd7, 32'hffff_fffe, 1'b1, 32'hffff_ffff, ST_OK);
      add_row(CMD_OR, 32'hf0f0_0000, 32'h0f0f_ffff, 1'b0, 32'd0, ST_OK);
      add_row(CMD_XOR, 32'hffff_ffff, 32'h5555_5555, 1'b0, 32'd0, ST_OK);
      add_row(CMD_AND, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'd0, ST_OK);
      add_row(CMD_SHL, 32'd1, 32'hffff_ffff, 1'b1, 32'd0, ST_SHIFT);
      add_row(CMD_SAR, MinVal, MinVal, 1'b1, 32'd0, ST_SHIFT);
      add_row(CMD_SHL, MaxVal, 32'd32, 1'b1, 32'd0, ST_OK);
      add_row(CMD_SAR, MinVal, MaxVal, 1'b1, 32'hffff_ffff, ST_OK);
      add_row(CMD_SHL, 32'hc000_0001, 32'd1, 1'b1, 32'h8000_0002, ST_OK);
      add_row(CMD_SAR, MinVal, 32'd31, 1'b1, 32'hffff_ffff, ST_OK);
      add_row(4'd15, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'd0, ST_OK);

      foreach (vectors[i]) begin
         got = alu_result(vectors[i].req);
         if (vectors[i].known && got !== vectors[i].rsp)
            report_mismatch($sformatf("table row %0d disagrees with prediction", i));
         send_item(vectors[i].req);
      end

      phase_len = NumRandom / 3;
      for (int i = 0; i < NumRandom; i++) begin
         if (i == phase_len) begin
            send_idle_pct = 60;
            recv_idle_pct = 29;
         end else if (i == 2 * phase_len) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         r.command = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                  : 4'($urandom_range(0, 10));
         r.left = random_operand();
         r.right = random_operand();
         if ((r.command == CMD_SHL || r.command == CMD_SAR) && $urandom_range(0, 1))
            r.right = $urandom_range(0, 33);
         send_item(r);
      end
      req_valid <= 1'b0;

      while (pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("checked_int32_alu_test: clean");
      else
         $display("checked_int32_alu_test: errors");
      $finish;
   end

endmodule
